[src/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key/value cache
// Beat formats, the token that walks the cell chain, and the sequencer states.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES_DEFAULT = 16;
	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int CAP_W           = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [VAL_W-1:0] READ_MISS = '1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} in_beat_t;

	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] read_value;
	} out_beat_t;

	// Request traveling down the chain, one cell per cycle.
	typedef struct packed {
		logic             active;
		logic             is_set;
		logic             done;
		logic             grow_ok;
		logic             grew;
		logic             found;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] carry_key;
		logic [VAL_W-1:0] carry_value;
		logic [VAL_W-1:0] rd_value;
	} token_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

endpackage

[src/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell: one slot of the recency-ordered chain
// Holds one key/value entry, registers the token from its left neighbor,
// acts on it and hands it (with any displaced entry) to the right neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  lkvc_pkg::token_t tok_i,
	output lkvc_pkg::token_t tok_o
);

	lkvc_pkg::token_t                 tok_q;
	logic                             act_q;
	logic                             valid_q;
	logic [lkvc_pkg::KEY_W-1:0]       key_q;
	logic [lkvc_pkg::VAL_W-1:0]       value_q;

	logic hit;
	logic live;
	logic wr_en;
	logic grow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_i.active;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_i;
	end

	always_comb begin
		hit   = valid_q && (key_q == tok_q.key);
		live  = act_q && !tok_q.done;
		wr_en = 1'b0;
		grow  = 1'b0;
		tok_o        = tok_q;
		tok_o.active = act_q;
		if (live) begin
			if (tok_q.is_set) begin
				if (hit) begin
					// land the displaced entry over the old copy of the key
					wr_en      = 1'b1;
					tok_o.done = 1'b1;
				end else if (valid_q) begin
					// take the carried entry, pass ours one place older
					wr_en             = 1'b1;
					tok_o.carry_key   = key_q;
					tok_o.carry_value = value_q;
				end else begin
					// first empty slot: grow here or drop the oldest entry
					wr_en      = tok_q.grow_ok;
					grow       = tok_q.grow_ok;
					tok_o.grew = tok_q.grow_ok;
					tok_o.done = 1'b1;
				end
			end else begin
				if (hit) begin
					tok_o.found    = 1'b1;
					tok_o.rd_value = value_q;
					tok_o.done     = 1'b1;
				end else if (!valid_q) begin
					tok_o.done = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (grow) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q   <= tok_q.carry_key;
			value_q <= tok_q.carry_value;
		end
	end

endmodule

[src/lru_key_value_cache_core.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key/value cache, LRU by set
// Entries sit in a chain of cells ordered by recency, most recent at cell 0.
// A request walks the chain as a token; a set shifts entries one place older
// up to the hit slot, the first empty slot, or off the end (eviction).
// ----------------------------------------------------------------------------
//
//  channel | beat          | handshake           | direction
//  --------+---------------+---------------------+----------
//  in      | in_beat_t     | in_valid / in_stall  | into core
//  out     | out_beat_t    | out_valid / out_stall| out of core
//  cfg     | capacity, 5 b | cfg_wr_en            | into core
//
//  One request at a time: the token walks the chain one cell per cycle, and
//  a new request is taken only once the sequencer has returned to idle after
//  the token leaves the last cell.
//  A get result appears on out the cycle after the token leaves the last cell.
//  Reset clears all valid marks, the entry count and the sequencer; capacity
//  resets to 16.
//  A waiting result does not block a new beat if it drains in the same cycle.
//
module lru_key_value_cache_core #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lkvc_pkg::in_beat_t            in_beat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lkvc_pkg::out_beat_t           out_beat,
	input  logic                          cfg_wr_en,
	input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wr_data
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	lkvc_pkg::state_t state_q, state_d;

	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]           count_q;
	logic                       out_valid_q;
	lkvc_pkg::out_beat_t        out_beat_q;

	logic in_accept;
	logic out_take;
	logic grow_ok;
	logic cap_zero;

	lkvc_pkg::token_t launch;
	lkvc_pkg::token_t tok_link [ENTRIES+1];
	lkvc_pkg::token_t tok_exit;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (in_accept) state_d = lkvc_pkg::ST_WALK;
			end
			lkvc_pkg::ST_WALK: begin
				if (tok_exit.active) state_d = lkvc_pkg::ST_IDLE;
			end
			default: state_d = lkvc_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs; take a beat only when the chain is empty and the
	// result slot is free by the time this request could come out
	always_comb begin
		unique case (state_q)
			lkvc_pkg::ST_IDLE: in_stall = out_valid_q && out_stall;
			lkvc_pkg::ST_WALK: in_stall = 1'b1;
			default:           in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	// a new key may grow the store only below min(capacity, ENTRIES)
	assign grow_ok  = (CMP_W'(count_q) < CMP_W'(capacity_q))
	               && (count_q < CNT_W'(ENTRIES));
	assign cap_zero = (capacity_q == '0);

	always_comb begin
		launch             = '0;
		launch.active      = in_accept;
		launch.is_set      = (in_beat.opcode == lkvc_pkg::OP_SET);
		// with capacity zero a set passes through with no effect
		launch.done        = (in_beat.opcode == lkvc_pkg::OP_SET) && cap_zero;
		launch.grow_ok     = grow_ok;
		launch.key         = in_beat.key;
		launch.carry_key   = in_beat.key;
		launch.carry_value = in_beat.value;
		launch.rd_value    = lkvc_pkg::READ_MISS;
	end

	assign tok_link[0] = launch;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (tok_link[i]),
			.tok_o  (tok_link[i+1])
		);
	end

	assign tok_exit = tok_link[ENTRIES];

	// entry count: advance when a set filled an empty slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (tok_exit.active && tok_exit.is_set && tok_exit.grew) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// result register: load a get result as it leaves the chain, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_exit.active && !tok_exit.is_set) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_exit.active && !tok_exit.is_set) begin
			out_beat_q.found      <= tok_exit.found;
			out_beat_q.read_value <= tok_exit.rd_value;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	// a leaving get result never lands on an untaken one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_exit.active && !tok_exit.is_set) |-> !out_valid_q)
		else $error("get result overwrote a pending result");

	// a token leaves the chain only while a request is walking
	a_exit_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit.active |-> (state_q == lkvc_pkg::ST_WALK))
		else $error("token left the chain with no request in flight");

	// an accepted beat reaches the chain end once it has passed all ENTRIES cells
	a_exit_timing: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> ##ENTRIES tok_exit.active)
		else $error("token did not reach the chain end on time");

	// the store never holds more than its slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond slot count");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU key/value cache core
// Drives get/set beats from a request queue through a valid/stall driver,
// mirrors the cache in a behavioral copy (slots, recency ages, fill count and
// capacity register), and checks every get result beat field by field in
// order. Phases sweep the capacity register and the idle/stall mix.
// ----------------------------------------------------------------------------
module tb;

	localparam int ENTRIES     = lkvc_pkg::ENTRIES_DEFAULT;
	localparam int POOL_SIZE   = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	// A set leaves no result, so let its walk through the chain finish.
	localparam int SETTLE      = ENTRIES + 4;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	lkvc_pkg::in_beat_t            in_beat = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	lkvc_pkg::out_beat_t           out_beat;
	logic                          cfg_wr_en = 1'b0;
	logic [lkvc_pkg::CAP_W-1:0]    cfg_wr_data = '0;

	lru_key_value_cache_core #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Behavioral copy of the cache. Age 0 is the most recently set slot.
	// ------------------------------------------------------------------
	logic [lkvc_pkg::KEY_W-1:0]  line_key [ENTRIES];
	logic [lkvc_pkg::VAL_W-1:0]  line_val [ENTRIES];
	bit                          line_vld [ENTRIES];
	int unsigned                 line_age [ENTRIES];
	int unsigned                 line_count;
	logic [lkvc_pkg::CAP_W-1:0]  cap_reg;

	lkvc_pkg::out_beat_t         pending_reads[$];  // get results still owed by the core
	lkvc_pkg::in_beat_t          req_fifo[$];       // beats waiting for the driver

	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	int                hold_seq = 0;
	int                hold_seen = 0;
	int                hold_left = 0;
	int                n_issued = 0;
	int                n_accepted = 0;
	int                fail_cnt = 0;
	int                quiet_cycles = 0;
	logic [lkvc_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];

	// Make slot s the newest: every valid slot newer than it ages by one.
	function automatic void make_newest(int s);
		int unsigned a;
		a = line_age[s];
		for (int i = 0; i < ENTRIES; i++)
			if (line_vld[i] && line_age[i] < a)
				line_age[i]++;
		line_age[s] = 0;
	endfunction

	// Apply one accepted beat to the copy; a get queues the result it owes.
	task automatic apply_request(lkvc_pkg::in_beat_t b);
		int                  hit;
		int                  slot;
		int unsigned         eff_cap;
		lkvc_pkg::out_beat_t rd;
		hit = -1;
		slot = -1;
		eff_cap = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && line_vld[i] && line_key[i] == b.key)
				hit = i;
		if (b.opcode == lkvc_pkg::OP_GET) begin
			rd.found      = (hit >= 0);
			rd.read_value = (hit >= 0) ? line_val[hit] : lkvc_pkg::READ_MISS;
			pending_reads.push_back(rd);
			return;
		end
		// Capacity zero drops every set.
		if (eff_cap == 0)
			return;
		if (hit >= 0) begin
			line_val[hit] = b.value;
			make_newest(hit);
		end else if (line_count < eff_cap) begin
			// Room left: take the first free slot and age everyone else.
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !line_vld[i])
					slot = i;
			if (slot < 0)
				return;
			for (int i = 0; i < ENTRIES; i++)
				if (line_vld[i])
					line_age[i]++;
			line_vld[slot] = 1'b1;
			line_age[slot] = 0;
			line_key[slot] = b.key;
			line_val[slot] = b.value;
			line_count++;
		end else begin
			// Full, or capacity lowered below the fill: replace the oldest
			// slot in place, count unchanged.
			for (int i = 0; i < ENTRIES; i++)
				if (line_vld[i] && (slot < 0 || line_age[i] > line_age[slot]))
					slot = i;
			if (slot < 0)
				return;
			make_newest(slot);
			line_key[slot] = b.key;
			line_val[slot] = b.value;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: hold a beat until it is taken, then offer the next one or idle.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_beat  <= '0;
		end else if (!in_valid || !in_stall) begin
			if (req_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_beat  <= req_fifo.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall, or a long hold-off when one is requested.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check result beats in order, predict from accepted requests,
	// and end the run if neither channel moves for too long.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (pending_reads.size() == 0) begin
					$error("result beat with no get outstanding: found=%0d read_value=%h",
						out_beat.found, out_beat.read_value);
					fail_cnt++;
				end else begin
					lkvc_pkg::out_beat_t exp_rd;
					exp_rd = pending_reads.pop_front();
					if (out_beat.found !== exp_rd.found) begin
						$error("found: expected %0d, got %0d", exp_rd.found, out_beat.found);
						fail_cnt++;
					end
					if (out_beat.read_value !== exp_rd.read_value) begin
						$error("read_value: expected %h, got %h",
							exp_rd.read_value, out_beat.read_value);
						fail_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				quiet_cycles = 0;
				apply_request(in_beat);
				n_accepted++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("tb failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_req(logic op, logic [lkvc_pkg::KEY_W-1:0] k,
		logic [lkvc_pkg::VAL_W-1:0] v);
		lkvc_pkg::in_beat_t b;
		b.opcode = op;
		b.key    = k;
		b.value  = v;
		req_fifo.push_back(b);
		n_issued++;
	endtask

	// Mostly keys from a small pool so gets hit and sets update or evict;
	// the rest fully random.
	task automatic push_random(int set_pct, int span);
		logic [lkvc_pkg::KEY_W-1:0] k;
		logic [lkvc_pkg::VAL_W-1:0] v;
		if ($urandom_range(99) < 85)
			k = key_pool[$urandom_range(span - 1)];
		else
			k = $urandom();
		case ($urandom_range(9))
			0: v = lkvc_pkg::READ_MISS;
			1: v = {1'b1, {(lkvc_pkg::VAL_W-1){1'b0}}};
			2: v = {1'b0, {(lkvc_pkg::VAL_W-1){1'b1}}};
			default: v = $urandom();
		endcase
		push_req(($urandom_range(99) < set_pct) ? lkvc_pkg::OP_SET : lkvc_pkg::OP_GET, k, v);
	endtask

	// Wait until every beat is taken and every result is back, then settle.
	task automatic drain();
		while (n_accepted != n_issued || pending_reads.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cap_reg = v;
		@(negedge clk);
	endtask

	task automatic run_phase(logic [lkvc_pkg::CAP_W-1:0] cap, int snd, int rcv, int n,
		int set_pct, int span);
		drain();
		write_capacity(cap);
		send_idle_pct  = snd;
		recv_stall_pct = rcv;
		repeat (n) push_random(set_pct, span);
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			line_key[i] = '0;
			line_val[i] = '0;
			line_vld[i] = 1'b0;
			line_age[i] = 0;
		end
		line_count = 0;
		cap_reg    = lkvc_pkg::CAP_RESET;
		key_pool[0] = {1'b1, {(lkvc_pkg::KEY_W-1){1'b0}}};
		key_pool[1] = {1'b0, {(lkvc_pkg::KEY_W-1){1'b1}}};
		key_pool[2] = '0;
		key_pool[3] = '1;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty lookup, extreme keys and values, update, miss.
		push_req(lkvc_pkg::OP_GET, '0, '0);
		push_req(lkvc_pkg::OP_SET, key_pool[0], {1'b0, {(lkvc_pkg::VAL_W-1){1'b1}}});
		push_req(lkvc_pkg::OP_SET, key_pool[1], {1'b1, {(lkvc_pkg::VAL_W-1){1'b0}}});
		push_req(lkvc_pkg::OP_SET, key_pool[2], '0);
		// A stored all-ones value differs from a miss only by found.
		push_req(lkvc_pkg::OP_SET, key_pool[3], '1);
		for (int i = 0; i < 4; i++)
			push_req(lkvc_pkg::OP_GET, key_pool[i], $urandom());
		push_req(lkvc_pkg::OP_SET, key_pool[2], 32'h1234_5678);
		push_req(lkvc_pkg::OP_GET, key_pool[2], '0);
		push_req(lkvc_pkg::OP_GET, 32'h5a5a_5a5a, '1);

		// Capacity zero: the set is dropped, held entries still answer.
		drain();
		write_capacity('0);
		push_req(lkvc_pkg::OP_SET, 32'h1357_9bdf, 32'h2468_ace0);
		push_req(lkvc_pkg::OP_GET, 32'h1357_9bdf, '0);
		push_req(lkvc_pkg::OP_GET, key_pool[0], '0);

		// Register maximum, clamped to the slot count; fill and evict.
		run_phase('1, 0, 0, 120, 55, POOL_SIZE);
		// Capacity lowered below the fill: sets replace in place.
		run_phase(5'd2, 88, 0, 100, 50, POOL_SIZE);
		run_phase(5'd1, 0, 88, 100, 50, 8);
		run_phase(lkvc_pkg::CAP_RESET, 16, 16, 120, 50, POOL_SIZE);
		run_phase('0, 0, 0, 30, 50, POOL_SIZE);

		// Long receiver hold-off while the sender keeps offering beats.
		run_phase(5'd5, 0, 0, 0, 0, POOL_SIZE);
		hold_seq++;
		repeat (60) push_random(30, 12);

		// Short bursts; the sender waits out every result between them.
		run_phase(lkvc_pkg::CAP_RESET, 16, 16, 0, 0, POOL_SIZE);
		for (int b = 0; b < 7; b++) begin
			repeat (10) push_random(50, POOL_SIZE);
			drain();
		end

		drain();
		if (fail_cnt == 0 && pending_reads.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
